[rtl/core/tlsf_free_list_index_top_defines.svh]
`ifndef TLSF_FREE_LIST_INDEX_TOP_DEFINES_SVH
`define TLSF_FREE_LIST_INDEX_TOP_DEFINES_SVH

// same-cycle check
`define TLFI_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle check
`define TLFI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/tlfi_pkg.sv]
package tlfi_pkg;

  localparam int FIRST_COUNT  = 32;
  localparam int SECOND_COUNT = 32;
  localparam int BLOCK_COUNT  = 1024;

  localparam int CMD_W  = 2;
  localparam int FL_W   = 5;
  localparam int SL_W   = 5;
  localparam int BLK_W  = 10;
  localparam int MAP_W  = 32;
  localparam int MAP_IW = $clog2(MAP_W);

  localparam int SLOT_COUNT = FIRST_COUNT * SECOND_COUNT;
  localparam int SLOT_AW    = $clog2(SLOT_COUNT);
  localparam int LINK_AW    = $clog2(BLOCK_COUNT);

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_SEARCH = 2'd2,
    CMD_LOCATE = 2'd3
  } tlfi_op_e;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [FL_W-1:0]  first_level;
    logic [SL_W-1:0]  second_level;
    logic [BLK_W-1:0] block_id;
  } tlfi_in_t;

  typedef struct packed {
    logic             found;
    logic [FL_W-1:0]  found_first;
    logic [SL_W-1:0]  found_second;
    logic [BLK_W-1:0] found_block;
  } tlfi_out_t;

  typedef struct packed {
    logic load;
    logic srch1;
    logic srch2;
    logic mem_rd;
    logic hd_got;
    logic ins_wr;
    logic ins_fix;
    logic rem_wr;
    logic out_load;
  } tlfi_dp_cmd_t;

  typedef struct packed {
    logic in_ok;
    logic direct;
    logic up;
    logic s2_hit;
    logic head_nz;
    logic out_busy;
  } tlfi_dp_stat_t;

  function automatic logic [MAP_W-1:0] mask_from(input logic [MAP_IW:0] pos);
    logic [MAP_W-1:0] m;
    m = '1;
    if (32'(pos) >= MAP_W) begin
      m = '0;
    end else begin
      m = m << pos;
    end
    return m;
  endfunction

  function automatic logic [MAP_IW-1:0] lowest_set(input logic [MAP_W-1:0] v);
    logic [MAP_IW-1:0] r;
    r = '0;
    for (int i = MAP_W - 1; i >= 0; i--) begin
      if (v[i]) begin
        r = MAP_IW'(i);
      end
    end
    return r;
  endfunction

endpackage

[rtl/core/tlfi_ctrl.sv]
module tlfi_ctrl import tlfi_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic [CMD_W-1:0] in_cmd_i,
  input  tlfi_dp_stat_t    stat_i,
  output logic             in_ready_o,
  output tlfi_dp_cmd_t     cmd_o
);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_SRCH1 = 4'd1;
  localparam logic [3:0] ST_SRCH2 = 4'd2;
  localparam logic [3:0] ST_HRD   = 4'd3;
  localparam logic [3:0] ST_HGOT  = 4'd4;
  localparam logic [3:0] ST_INS   = 4'd5;
  localparam logic [3:0] ST_INS2  = 4'd6;
  localparam logic [3:0] ST_LRD   = 4'd7;
  localparam logic [3:0] ST_REM   = 4'd8;
  localparam logic [3:0] ST_DONE  = 4'd9;

  logic [3:0]       state_q, state_d;
  logic [CMD_W-1:0] op_q, op_d;

  always_comb begin
    state_d    = state_q;
    op_d       = op_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          op_d       = in_cmd_i;
          case (in_cmd_i)
            CMD_INSERT: state_d = stat_i.in_ok ? ST_HRD : ST_DONE;
            CMD_REMOVE: state_d = stat_i.in_ok ? ST_LRD : ST_DONE;
            default:    state_d = ST_SRCH1;
          endcase
        end
      end
      ST_SRCH1: begin
        cmd_o.srch1 = 1'b1;
        if (stat_i.direct) begin
          state_d = ST_HRD;
        end else if (stat_i.up) begin
          state_d = ST_SRCH2;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_SRCH2: begin
        cmd_o.srch2 = 1'b1;
        state_d     = stat_i.s2_hit ? ST_HRD : ST_DONE;
      end
      ST_HRD: begin
        cmd_o.mem_rd = 1'b1;
        state_d      = (op_q == CMD_INSERT) ? ST_INS : ST_HGOT;
      end
      ST_HGOT: begin
        cmd_o.hd_got = 1'b1;
        state_d      = (op_q == CMD_LOCATE && stat_i.head_nz) ? ST_LRD : ST_DONE;
      end
      ST_INS: begin
        cmd_o.ins_wr = 1'b1;
        state_d      = stat_i.head_nz ? ST_INS2 : ST_DONE;
      end
      ST_INS2: begin
        cmd_o.ins_fix = 1'b1;
        state_d       = ST_DONE;
      end
      ST_LRD: begin
        cmd_o.mem_rd = 1'b1;
        state_d      = ST_REM;
      end
      ST_REM: begin
        cmd_o.rem_wr = 1'b1;
        state_d      = ST_DONE;
      end
      ST_DONE: begin
        if (!stat_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      op_q    <= CMD_INSERT;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
    end
  end

endmodule

[rtl/core/tlfi_dp.sv]
`include "tlsf_free_list_index_top_defines.svh"

module tlfi_dp import tlfi_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  tlfi_in_t      in_word_i,
  input  logic          out_ready_i,
  input  tlfi_dp_cmd_t  cmd_i,
  output tlfi_dp_stat_t stat_o,
  output logic          out_valid_o,
  output tlfi_out_t     out_word_o
);

  logic [FL_W-1:0]  fl_q;
  logic [SL_W-1:0]  sl_q;
  logic [BLK_W-1:0] blk_q;
  logic             found_q;

  logic [MAP_W-1:0] top_q;
  logic [MAP_W-1:0] sec_q [FIRST_COUNT];

  logic [BLK_W-1:0] head_mem [SLOT_COUNT];
  logic [BLK_W-1:0] next_mem [BLOCK_COUNT];
  logic [BLK_W-1:0] prev_mem [BLOCK_COUNT];

  logic [BLK_W-1:0] head_rd_q, next_rd_q, prev_rd_q;
  logic             hv_q;

  logic             out_valid_q;
  tlfi_out_t        out_word_q;

  logic [SLOT_AW-1:0] slot;
  logic [MAP_W-1:0]   sec_rd, smap1, fmap;
  logic               fl_ok;
  logic [BLK_W-1:0]   head_eff;
  logic               head_hit;

  logic               hd_we, nx_we, pv_we;
  logic [BLK_W-1:0]   hd_wd, nx_wd, pv_wd;
  logic [BLK_W-1:0]   nx_wa, pv_wa;

  assign slot     = SLOT_AW'(32'(fl_q) * SECOND_COUNT + 32'(sl_q));
  assign sec_rd   = sec_q[fl_q];
  assign smap1    = sec_rd & mask_from({1'b0, sl_q});
  assign fmap     = top_q & mask_from((MAP_IW + 1)'(fl_q) + (MAP_IW + 1)'(1));
  assign fl_ok    = 32'(fl_q) < FIRST_COUNT;
  // head entries only count while their list bit is set
  assign head_eff = hv_q ? head_rd_q : '0;
  assign head_hit = head_eff == blk_q;

  assign stat_o.in_ok    = (32'(in_word_i.first_level) < FIRST_COUNT)
                        && (32'(in_word_i.second_level) < SECOND_COUNT)
                        && (in_word_i.block_id != '0)
                        && (32'(in_word_i.block_id) < BLOCK_COUNT);
  assign stat_o.direct   = fl_ok && (smap1 != '0);
  assign stat_o.up       = fl_ok && (fmap != '0);
  assign stat_o.s2_hit   = sec_rd != '0;
  assign stat_o.head_nz  = head_eff != '0;
  assign stat_o.out_busy = out_valid_q && !out_ready_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      fl_q  <= in_word_i.first_level;
      sl_q  <= in_word_i.second_level;
      blk_q <= in_word_i.block_id;
    end else if (cmd_i.srch1) begin
      if (smap1 != '0) begin
        sl_q <= SL_W'(lowest_set(smap1));
      end else begin
        fl_q <= FL_W'(lowest_set(fmap));
      end
    end else if (cmd_i.srch2) begin
      sl_q <= SL_W'(lowest_set(sec_rd));
    end else if (cmd_i.hd_got) begin
      blk_q <= head_eff;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else if (cmd_i.load) begin
      found_q <= 1'b0;
    end else if (cmd_i.hd_got) begin
      found_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_q <= '0;
      for (int i = 0; i < FIRST_COUNT; i++) begin
        sec_q[i] <= '0;
      end
    end else if (cmd_i.ins_wr) begin
      top_q[fl_q]       <= 1'b1;
      sec_q[fl_q][sl_q] <= 1'b1;
    end else if (cmd_i.rem_wr && head_hit && next_rd_q == '0) begin
      sec_q[fl_q][sl_q] <= 1'b0;
      if ((sec_rd & ~(MAP_W'(1) << sl_q)) == '0) begin
        top_q[fl_q] <= 1'b0;
      end
    end
  end

  // write ports of the three stores
  always_comb begin
    hd_we = cmd_i.ins_wr || (cmd_i.rem_wr && head_hit);
    hd_wd = cmd_i.ins_wr ? blk_q : next_rd_q;

    nx_we = cmd_i.ins_wr || (cmd_i.rem_wr && prev_rd_q != '0);
    nx_wa = cmd_i.ins_wr ? blk_q : prev_rd_q;
    nx_wd = cmd_i.ins_wr ? head_eff : next_rd_q;

    pv_we = cmd_i.ins_wr || cmd_i.ins_fix || (cmd_i.rem_wr && next_rd_q != '0);
    pv_wa = next_rd_q;
    pv_wd = prev_rd_q;
    if (cmd_i.ins_wr) begin
      pv_wa = blk_q;
      pv_wd = '0;
    end else if (cmd_i.ins_fix) begin
      pv_wa = head_eff;
      pv_wd = blk_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (hd_we) begin
      head_mem[slot] <= hd_wd;
    end
    if (cmd_i.mem_rd) begin
      head_rd_q <= head_mem[slot];
      hv_q      <= sec_rd[sl_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (nx_we) begin
      next_mem[nx_wa[LINK_AW-1:0]] <= nx_wd;
    end
    if (cmd_i.mem_rd) begin
      next_rd_q <= next_mem[blk_q[LINK_AW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pv_we) begin
      prev_mem[pv_wa[LINK_AW-1:0]] <= pv_wd;
    end
    if (cmd_i.mem_rd) begin
      prev_rd_q <= prev_mem[blk_q[LINK_AW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_word_q.found        <= found_q;
      out_word_q.found_first  <= found_q ? fl_q : '0;
      out_word_q.found_second <= found_q ? sl_q : '0;
      out_word_q.found_block  <= found_q ? blk_q : '0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  `TLFI_ASSERT_NOW(a_top_tracks_second, cmd_i.mem_rd, top_q[fl_q] == (sec_q[fl_q] != '0), "first-level bit out of step with its second-level map")
  `TLFI_ASSERT_NEXT(a_insert_marks_list, cmd_i.ins_wr, sec_q[fl_q][sl_q] && top_q[fl_q], "insert left its list unmarked")
  `TLFI_ASSERT_NOW(a_load_when_free, cmd_i.out_load, !out_valid_q || out_ready_i, "result word overwritten before it was taken")

endmodule

[rtl/core/tlsf_free_list_index_top.sv]
// channel   dir  handshake               word
// in        in   in_valid_i/in_ready_o    in_word_i   (cmd, levels, block)
// out       out  out_valid_o/out_ready_i  out_word_o  (found, levels, block)
//
// an insert reads the head, writes the links, and fixes the old head's back link if any;
// a remove reads the block's links and unlinks it; a search runs a first-level and, if
// needed, a second-level map search, then reads the head; a locate also unlinks that head
// reset clears the bitmaps but not the head and link stores; a head entry counts only while its list bit is set
// the next word is taken while a result waits in the output register; a further
// result holds the controller in its final state until that register frees
module tlsf_free_list_index_top import tlfi_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  tlfi_in_t  in_word_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output tlfi_out_t out_word_o
);

  tlfi_dp_cmd_t  dp_cmd;
  tlfi_dp_stat_t dp_stat;

  tlfi_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_cmd_i   (in_word_i.cmd),
    .stat_i     (dp_stat),
    .in_ready_o (in_ready_o),
    .cmd_o      (dp_cmd)
  );

  tlfi_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_word_i   (in_word_i),
    .out_ready_i (out_ready_i),
    .cmd_i       (dp_cmd),
    .stat_o      (dp_stat),
    .out_valid_o (out_valid_o),
    .out_word_o  (out_word_o)
  );

endmodule
